// ===== hw/rtl/tcb_spline_point_eval_core_macros.svh =====
// assertion macros shared by the tcb spline point evaluator rtl
// plain text macros, no dependencies; include by bare file name
`ifndef TCB_SPLINE_POINT_EVAL_CORE_MACROS_SVH
`define TCB_SPLINE_POINT_EVAL_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TCBSPL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define TCBSPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcbspl_pkg.sv =====
// shared types, widths and fixed-point constants of the tcb spline point evaluator
// no dependencies; imported by every module of the block
package tcbspl_pkg;

  localparam int CoordW    = 16;
  localparam int UposW     = 16;
  localparam int FracBits  = 12;
  localparam int QOne      = 1 << FracBits;
  localparam int CfgIdxW   = 2;
  localparam int WgtW      = 22;
  localparam int BasisW    = 18;
  localparam int LaneDepth = 9;
  localparam int Latency   = LaneDepth + 1;
  localparam int CoordMax  = (1 << (CoordW - 1)) - 1;
  localparam int CoordMin  = -(1 << (CoordW - 1));

  typedef logic [UposW-1:0]          upos_t;
  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [WgtW-1:0]    wgt_t;
  typedef logic signed [BasisW-1:0]  basis_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TENSION    = 2'd0,
    REG_CONTINUITY = 2'd1,
    REG_BIAS       = 2'd2
  } cfg_reg_t;

  // tangent weights, q12
  typedef struct packed {
    wgt_t wa;
    wgt_t wb;
    wgt_t wc;
    wgt_t wd;
  } weights_t;

  // hermite basis values, q16
  typedef struct packed {
    basis_t h00;
    basis_t h01;
    basis_t h10;
    basis_t h11;
  } basis_set_t;

  typedef struct packed {
    coord_t value;
    logic   clip;
  } lane_out_t;

endpackage

// ===== hw/rtl/tcbspl_weights.sv =====
// tension / continuity / bias registers and the two-stage tangent weight pipeline
// depends on tcbspl_pkg
module tcbspl_weights (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  tcbspl_pkg::cfg_idx_t cfg_idx,
  input  tcbspl_pkg::coord_t   cfg_wdata,
  output tcbspl_pkg::weights_t weights
);
  import tcbspl_pkg::*;

  localparam int FactW  = CoordW + 1;
  localparam int Prod2W = 2 * FactW - 2;
  localparam int Prod3W = Prod2W + FactW;
  localparam int WShift = 2 * FracBits + 1;
  localparam logic signed [Prod3W-1:0] WRound = Prod3W'(1) <<< (WShift - 1);

  coord_t tension;
  coord_t continuity;
  coord_t bias;

  logic signed [FactW-1:0]  omt, opb, omb, opc, omc;
  logic signed [Prod2W-1:0] tb, tm;
  logic signed [FactW-1:0]  opc_r, omc_r;
  logic signed [Prod3W-1:0] wa_full, wb_full, wc_full, wd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension    <= '0;
      continuity <= '0;
      bias       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TENSION:    tension    <= cfg_wdata;
        REG_CONTINUITY: continuity <= cfg_wdata;
        REG_BIAS:       bias       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // factors are exact in q12
  assign omt = FactW'(QOne) - FactW'(tension);
  assign opb = FactW'(QOne) + FactW'(bias);
  assign omb = FactW'(QOne) - FactW'(bias);
  assign opc = FactW'(QOne) + FactW'(continuity);
  assign omc = FactW'(QOne) - FactW'(continuity);

  always_ff @(posedge clk) begin
    tb    <= Prod2W'(omt) * Prod2W'(opb);
    tm    <= Prod2W'(omt) * Prod2W'(omb);
    opc_r <= opc;
    omc_r <= omc;
  end

  // 0.5 * f1 * f2 * f3, q36 rounded half up to q12
  assign wa_full = Prod3W'(tb) * Prod3W'(omc_r) + WRound;
  assign wb_full = Prod3W'(tm) * Prod3W'(opc_r) + WRound;
  assign wc_full = Prod3W'(tb) * Prod3W'(opc_r) + WRound;
  assign wd_full = Prod3W'(tm) * Prod3W'(omc_r) + WRound;

  always_ff @(posedge clk) begin
    weights.wa <= WgtW'(wa_full >>> WShift);
    weights.wb <= WgtW'(wb_full >>> WShift);
    weights.wc <= WgtW'(wc_full >>> WShift);
    weights.wd <= WgtW'(wd_full >>> WShift);
  end

endmodule

// ===== hw/rtl/tcbspl_basis.sv =====
// three-stage hermite basis generator: u -> u^2 -> u^3 -> h00 h01 h10 h11 in q16
// depends on tcbspl_pkg
module tcbspl_basis (
  input  logic                   clk,
  input  tcbspl_pkg::upos_t      u_pos,
  output tcbspl_pkg::basis_set_t basis
);
  import tcbspl_pkg::*;

  localparam int SqW    = 2 * UposW;
  localparam int CubeW  = 3 * UposW;
  localparam int SumW   = CubeW + 4;
  localparam int BShift = 2 * UposW;
  localparam logic signed [SumW-1:0] BUnit = SumW'(1) <<< CubeW;
  localparam logic signed [SumW-1:0] BHalf = SumW'(1) <<< (BShift - 1);

  upos_t            u_s1, u_s2;
  logic [SqW-1:0]   sq_s1, sq_s2;
  logic [CubeW-1:0] cube_s2;

  logic signed [SumW-1:0] s3, s2, s1;
  logic signed [SumW-1:0] sum00, sum01, sum10, sum11;

  always_ff @(posedge clk) begin
    u_s1    <= u_pos;
    sq_s1   <= SqW'(u_pos) * SqW'(u_pos);
    u_s2    <= u_s1;
    sq_s2   <= sq_s1;
    cube_s2 <= CubeW'(sq_s1) * CubeW'(u_s1);
  end

  // all terms aligned to q48
  assign s3 = $signed(SumW'(cube_s2));
  assign s2 = $signed(SumW'(sq_s2) << UposW);
  assign s1 = $signed(SumW'(u_s2) << SqW);

  assign sum00 = (s3 <<< 1) - (s2 + (s2 <<< 1)) + BUnit + BHalf;
  assign sum01 = (s2 + (s2 <<< 1)) - (s3 <<< 1) + BHalf;
  assign sum10 = s3 - (s2 <<< 1) + s1 + BHalf;
  assign sum11 = s3 - s2 + BHalf;

  always_ff @(posedge clk) begin
    basis.h00 <= BasisW'(sum00 >>> BShift);
    basis.h01 <= BasisW'(sum01 >>> BShift);
    basis.h10 <= BasisW'(sum10 >>> BShift);
    basis.h11 <= BasisW'(sum11 >>> BShift);
  end

endmodule

// ===== hw/rtl/tcbspl_lane.sv =====
// one coordinate lane: differences, tangents, basis blend, rounding and saturation
// nine pipeline stages; depends on tcbspl_pkg
module tcbspl_lane (
  input  logic                   clk,
  input  tcbspl_pkg::coord_t     p0,
  input  tcbspl_pkg::coord_t     p1,
  input  tcbspl_pkg::coord_t     p2,
  input  tcbspl_pkg::coord_t     p3,
  input  tcbspl_pkg::weights_t   weights,
  input  tcbspl_pkg::basis_set_t basis,
  output tcbspl_pkg::lane_out_t  result
);
  import tcbspl_pkg::*;

  localparam int DiffW    = CoordW + 1;
  localparam int TanW     = WgtW + DiffW;
  localparam int HpW      = BasisW + CoordW;
  localparam int HsW      = HpW + 1;
  localparam int SplitW   = 20;
  localparam int LoW      = BasisW + SplitW + 1;
  localparam int HiW      = BasisW + TanW - SplitW;
  localparam int AccW     = BasisW + TanW;
  localparam int AccShift = FracBits + UposW;
  localparam int RndW     = AccW - AccShift;
  localparam logic signed [AccW-1:0] ARound = AccW'(1) <<< (AccShift - 1);

  typedef logic signed [DiffW-1:0] diff_t;

  typedef struct packed {
    coord_t p1;
    coord_t p2;
    diff_t  d10;
    diff_t  d21;
    diff_t  d32;
  } geo_t;

  geo_t geo_in;
  geo_t geo_pipe [3];

  logic signed [TanW-1:0]   pa, pb, pc, pd;
  logic signed [HpW-1:0]    hp1, hp2;
  basis_t                   h10_s4, h11_s4, h10_s5, h11_s5;
  logic signed [TanW-1:0]   m1, m2;
  logic signed [HsW-1:0]    s12_s5, s12_s6, s12_s7;
  logic signed [SplitW:0]   m1_lo, m2_lo;
  logic signed [TanW-SplitW-1:0] m1_hi, m2_hi;
  logic signed [LoW-1:0]    pl1, pl2;
  logic signed [HiW-1:0]    ph1, ph2;
  logic signed [AccW-1:0]   q1, q2, acc;
  logic signed [RndW-1:0]   rsh;
  coord_t                   sat_value;
  logic                     sat_clip;

  assign geo_in.p1  = p1;
  assign geo_in.p2  = p2;
  assign geo_in.d10 = DiffW'(p1) - DiffW'(p0);
  assign geo_in.d21 = DiffW'(p2) - DiffW'(p1);
  assign geo_in.d32 = DiffW'(p3) - DiffW'(p2);

  // stages 1..3: wait for the basis values
  always_ff @(posedge clk) begin
    geo_pipe[0] <= geo_in;
    geo_pipe[1] <= geo_pipe[0];
    geo_pipe[2] <= geo_pipe[1];
  end

  // stage 4: weight * difference (q24), basis * point (q28)
  always_ff @(posedge clk) begin
    pa     <= TanW'(weights.wa) * TanW'(geo_pipe[2].d10);
    pb     <= TanW'(weights.wb) * TanW'(geo_pipe[2].d21);
    pc     <= TanW'(weights.wc) * TanW'(geo_pipe[2].d21);
    pd     <= TanW'(weights.wd) * TanW'(geo_pipe[2].d32);
    hp1    <= HpW'(basis.h00) * HpW'(geo_pipe[2].p1);
    hp2    <= HpW'(basis.h01) * HpW'(geo_pipe[2].p2);
    h10_s4 <= basis.h10;
    h11_s4 <= basis.h11;
  end

  // stage 5: tangents
  always_ff @(posedge clk) begin
    m1     <= pa + pb;
    m2     <= pc + pd;
    s12_s5 <= HsW'(hp1) + HsW'(hp2);
    h10_s5 <= h10_s4;
    h11_s5 <= h11_s4;
  end

  // tangent split into an unsigned low part and a signed high part
  assign m1_lo = $signed({1'b0, m1[SplitW-1:0]});
  assign m2_lo = $signed({1'b0, m2[SplitW-1:0]});
  assign m1_hi = $signed(m1[TanW-1:SplitW]);
  assign m2_hi = $signed(m2[TanW-1:SplitW]);

  // stage 6: partial products of basis * tangent
  always_ff @(posedge clk) begin
    pl1    <= LoW'(h10_s5) * LoW'(m1_lo);
    ph1    <= HiW'(h10_s5) * HiW'(m1_hi);
    pl2    <= LoW'(h11_s5) * LoW'(m2_lo);
    ph2    <= HiW'(h11_s5) * HiW'(m2_hi);
    s12_s6 <= s12_s5;
  end

  // stage 7: recombine partial products (q40)
  always_ff @(posedge clk) begin
    q1     <= (AccW'(ph1) <<< SplitW) + AccW'(pl1);
    q2     <= (AccW'(ph2) <<< SplitW) + AccW'(pl2);
    s12_s7 <= s12_s6;
  end

  // stage 8: q40 sum with rounding offset
  always_ff @(posedge clk) begin
    acc <= (AccW'(s12_s7) <<< FracBits) + q1 + q2 + ARound;
  end

  assign rsh = RndW'(acc >>> AccShift);

  always_comb begin
    sat_value = CoordW'(rsh);
    sat_clip  = 1'b0;
    if (rsh > RndW'(CoordMax)) begin
      sat_value = coord_t'(CoordMax);
      sat_clip  = 1'b1;
    end else if (rsh < RndW'(CoordMin)) begin
      sat_value = coord_t'(CoordMin);
      sat_clip  = 1'b1;
    end
  end

  // stage 9: saturated result
  always_ff @(posedge clk) begin
    result.value <= sat_value;
    result.clip  <= sat_clip;
  end

endmodule

// ===== hw/rtl/tcb_spline_point_eval_core.sv =====
// top level of the tcb (kochanek-bartels) spline point evaluator
// depends on tcbspl_pkg, tcbspl_weights, tcbspl_basis, tcbspl_lane and the macros header
//
// A start beat (start high, busy low) hands over u_pos and four 2-D control
// points; the block returns the point on the cubic hermite segment from
// point 1 to point 2 as out_x / out_y with a clipped flag, shown for exactly
// one cycle under the done strobe. The datapath is fully pipelined: busy
// never goes high, a new beat is taken every cycle, and the results come
// out in the order of their start beats. The depth is set by the lane
// pipeline: three stages of basis generation (u^2, u^3, basis sums), then
// tangent products, tangent sums, a split basis * tangent product over two
// stages, the final q40 sum, rounding with saturation, and the output
// register that merges the x and y lanes. There is no backpressure: the
// receiver must take every done beat as it comes. Tension, continuity and
// bias are written through cfg_we / cfg_idx / cfg_wdata (index 0, 1, 2;
// index 3 is ignored). The derived tangent weights run through a two-stage
// pipeline of their own and are read at the fourth lane stage, so a write
// applies to every beat accepted at or after the write edge.
`include "tcb_spline_point_eval_core_macros.svh"

module tcb_spline_point_eval_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we,
  input  tcbspl_pkg::cfg_idx_t cfg_idx,
  input  tcbspl_pkg::coord_t   cfg_wdata,
  input  tcbspl_pkg::upos_t    u_pos,
  input  tcbspl_pkg::coord_t   p0_x,
  input  tcbspl_pkg::coord_t   p0_y,
  input  tcbspl_pkg::coord_t   p1_x,
  input  tcbspl_pkg::coord_t   p1_y,
  input  tcbspl_pkg::coord_t   p2_x,
  input  tcbspl_pkg::coord_t   p2_y,
  input  tcbspl_pkg::coord_t   p3_x,
  input  tcbspl_pkg::coord_t   p3_y,
  output logic                 done,
  output tcbspl_pkg::coord_t   out_x,
  output tcbspl_pkg::coord_t   out_y,
  output logic                 clipped
);
  import tcbspl_pkg::*;

  logic                 accept;
  logic [LaneDepth-1:0] vld;    // one valid bit per lane stage
  weights_t             weights;
  basis_set_t           basis;
  lane_out_t            res_x;
  lane_out_t            res_y;
  logic                 out_at_bound;

  // fully pipelined, never holds off a start beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // config registers and tangent weights, shared by both lanes
  tcbspl_weights u_weights (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .weights   (weights)
  );

  // hermite basis from u, shared by both lanes
  tcbspl_basis u_basis (
    .clk   (clk),
    .u_pos (u_pos),
    .basis (basis)
  );

  // x lane
  tcbspl_lane u_lane_x (
    .clk     (clk),
    .p0      (p0_x),
    .p1      (p1_x),
    .p2      (p2_x),
    .p3      (p3_x),
    .weights (weights),
    .basis   (basis),
    .result  (res_x)
  );

  // y lane
  tcbspl_lane u_lane_y (
    .clk     (clk),
    .p0      (p0_y),
    .p1      (p1_y),
    .p2      (p2_y),
    .p3      (p3_y),
    .weights (weights),
    .basis   (basis),
    .result  (res_y)
  );

  // valid tracking runs alongside the free-running datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LaneDepth-2:0], accept};
      done <= vld[LaneDepth-1];
    end
  end

  // merge stage: both coordinates and a combined clip flag
  always_ff @(posedge clk) begin
    out_x   <= res_x.value;
    out_y   <= res_y.value;
    clipped <= res_x.clip | res_y.clip;
  end

  // some coordinate sits on a range bound
  assign out_at_bound = (out_x == coord_t'(CoordMax)) || (out_x == coord_t'(CoordMin)) ||
                        (out_y == coord_t'(CoordMax)) || (out_y == coord_t'(CoordMin));

  `TCBSPL_ASSERT_NEXT(a_start_to_done, clk, rst, start, ##(Latency-1) done, "start beat lost")
  `TCBSPL_ASSERT_IMPLY(a_done_from_start, clk, rst, done, $past(start, Latency), "spurious result")
  `TCBSPL_ASSERT_IMPLY(a_clip_at_bound, clk, rst, done && clipped, out_at_bound, "clip flag off bound")

endmodule
